// ===== hdl/toy_cpu_pkg.sv =====
package toy_cpu_pkg;

  localparam int NUM_REGS   = 8;
  localparam int DATA_WIDTH = 8;
  localparam int REG_IDX_W  = 3;
  localparam int PC_WIDTH   = 8;
  localparam int INSTR_W    = 20;
  localparam int TICK_W     = 32;

  // Instruction word fields
  localparam int OP_LSB  = 17;
  localparam int DST_LSB = 14;
  localparam int SRC_LSB = 11;
  localparam int TGT_LSB = 8;
  localparam int IMM_W   = 8;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [REG_IDX_W-1:0]  reg_idx_t;
  typedef logic [PC_WIDTH-1:0]   pc_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_ADDI = 3'd1,
    OP_MUL  = 3'd2,
    OP_INV  = 3'd3,
    OP_BR   = 3'd4,
    OP_LW   = 3'd5,
    OP_SW   = 3'd6,
    OP_HALT = 3'd7
  } opcode_t;

  // Branch condition lives in the dst field
  localparam reg_idx_t BR_EQ = 3'd0;
  localparam reg_idx_t BR_NE = 3'd1;
  localparam reg_idx_t BR_LT = 3'd2;

endpackage

// ===== hdl/toy_cpu_ram.sv =====
module toy_cpu_ram import toy_cpu_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== hdl/toy_cpu_execute_step.sv =====
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready   | started, instr_word, mem_done, mem_rdata
// out_    | output    | out_valid / out_ready | next_pc, mem_*, reg_*, halted, busy_wait,
//         |           |                       | tick_total
//
// One transaction per cycle while the output is not stalled: register operands
// are read from the register file RAM as the transaction is taken, the tick
// executes from the execute stage input register and its result lands in the
// output register. Synchronous active-low reset clears the core state and
// register valid bits. A stalled output holds the execute stage; input is still
// taken while the execute stage drains.
module toy_cpu_execute_step import toy_cpu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_started,
  input  logic [INSTR_W-1:0]    in_instr_word,
  input  logic                  in_mem_done,
  input  logic [DATA_WIDTH-1:0] in_mem_rdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PC_WIDTH-1:0]   out_next_pc,
  output logic                  out_mem_req,
  output logic                  out_mem_write,
  output logic [DATA_WIDTH-1:0] out_mem_addr,
  output logic [DATA_WIDTH-1:0] out_mem_wdata,
  output logic                  out_reg_we,
  output logic [REG_IDX_W-1:0]  out_reg_idx,
  output logic [DATA_WIDTH-1:0] out_reg_value,
  output logic                  out_halted,
  output logic                  out_busy_wait,
  output logic [TICK_W-1:0]     out_tick_total
);

  // Execute stage input register
  logic                  s1_valid_r;
  logic                  s1_started_r;
  logic [INSTR_W-1:0]    s1_instr_r;
  logic                  s1_done_r;
  data_t                 s1_rdata_r;
  logic                  src_byp_r, tgt_byp_r, src_vld_r, tgt_vld_r;
  data_t                 byp_data_r;

  // Core state
  pc_t                   pc_r, pc_nxt;
  logic [TICK_W-1:0]     tick_r, tick_nxt;
  logic                  halt_r, halt_nxt;
  logic                  skip_r, skip_nxt;
  logic                  mwait_r, mwait_nxt;
  logic                  ldpend_r, ldpend_nxt;
  reg_idx_t              lddest_r, lddest_nxt;
  logic [NUM_REGS-1:0]   rf_vld_r;

  // Output register
  logic                  out_valid_r;
  pc_t                   next_pc_r;
  logic                  mem_req_r, mem_write_r, reg_we_r, halted_r, busy_r;
  data_t                 mem_addr_r, mem_wdata_r, reg_value_r;
  reg_idx_t              reg_idx_r;
  logic [TICK_W-1:0]     tick_total_r;

  logic                  in_take, s1_adv;
  reg_idx_t              rd_src, rd_tgt;
  data_t                 ram_src_q, ram_tgt_q;
  data_t                 src_val, tgt_val;

  logic                  wr_en;
  reg_idx_t              wr_idx;
  data_t                 wr_val;
  logic                  req_c, write_c, busy_c;
  data_t                 addr_c, wdata_c;

  opcode_t               op;
  reg_idx_t              dst;
  logic [IMM_W-1:0]      imm;
  logic [2*4-1:0]        prod;
  logic                  take;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  assign rd_src = in_instr_word[SRC_LSB +: REG_IDX_W];
  assign rd_tgt = in_instr_word[TGT_LSB +: REG_IDX_W];

  toy_cpu_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_REGS)
  ) u_rf (
    .clk     (clk),
    .we      (s1_adv && wr_en),
    .waddr   (wr_idx),
    .wdata   (wr_val),
    .re      (in_take),
    .raddr_a (rd_src),
    .raddr_b (rd_tgt),
    .rdata_a (ram_src_q),
    .rdata_b (ram_tgt_q)
  );

  // Forward a write that lands on the same edge as the read; unwritten reads zero
  assign src_val = src_byp_r ? byp_data_r : (src_vld_r ? ram_src_q : '0);
  assign tgt_val = tgt_byp_r ? byp_data_r : (tgt_vld_r ? ram_tgt_q : '0);

  assign op   = opcode_t'(s1_instr_r[OP_LSB +: 3]);
  assign dst  = s1_instr_r[DST_LSB +: REG_IDX_W];
  assign imm  = s1_instr_r[IMM_W-1:0];
  assign prod = src_val[3:0] * src_val[7:4];

  always_comb begin
    pc_nxt     = pc_r;
    tick_nxt   = tick_r;
    halt_nxt   = halt_r;
    skip_nxt   = skip_r;
    mwait_nxt  = mwait_r;
    ldpend_nxt = ldpend_r;
    lddest_nxt = lddest_r;
    wr_en      = 1'b0;
    wr_idx     = '0;
    wr_val     = '0;
    req_c      = 1'b0;
    write_c    = 1'b0;
    addr_c     = '0;
    wdata_c    = '0;
    busy_c     = 1'b0;
    take       = 1'b0;
    if (s1_started_r && !halt_r) begin
      tick_nxt = tick_r + 1'b1;
      if (skip_r) begin
        skip_nxt = 1'b0;
        busy_c   = 1'b1;
      end else if (mwait_r) begin
        busy_c = 1'b1;
        if (s1_done_r) begin
          if (ldpend_r) begin
            wr_en  = 1'b1;
            wr_idx = lddest_r;
            wr_val = s1_rdata_r;
          end
          mwait_nxt  = 1'b0;
          ldpend_nxt = 1'b0;
        end
      end else begin
        pc_nxt = pc_r + 1'b1;
        case (op)
          OP_ADD: begin
            wr_en  = 1'b1;
            wr_idx = dst;
            wr_val = src_val + tgt_val;
          end
          OP_ADDI: begin
            wr_en  = 1'b1;
            wr_idx = dst;
            wr_val = src_val + imm;
          end
          OP_MUL: begin
            wr_en    = 1'b1;
            wr_idx   = dst;
            wr_val   = prod;
            skip_nxt = 1'b1;
          end
          OP_INV: begin
            wr_en  = 1'b1;
            wr_idx = dst;
            wr_val = ~src_val;
          end
          OP_BR: begin
            case (dst)
              BR_EQ:   take = (src_val == tgt_val);
              BR_NE:   take = (src_val != tgt_val);
              BR_LT:   take = ($signed(src_val) < $signed(tgt_val));
              default: take = 1'b0;
            endcase
            if (take) begin
              pc_nxt   = imm;
              skip_nxt = 1'b1;
            end
          end
          OP_LW: begin
            req_c      = 1'b1;
            addr_c     = tgt_val;
            mwait_nxt  = 1'b1;
            ldpend_nxt = 1'b1;
            lddest_nxt = dst;
          end
          OP_SW: begin
            req_c      = 1'b1;
            write_c    = 1'b1;
            addr_c     = tgt_val;
            wdata_c    = src_val;
            mwait_nxt  = 1'b1;
            ldpend_nxt = 1'b0;
          end
          default: begin
            halt_nxt = 1'b1;
          end
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      tick_r      <= '0;
      halt_r      <= 1'b0;
      skip_r      <= 1'b0;
      mwait_r     <= 1'b0;
      ldpend_r    <= 1'b0;
      lddest_r    <= '0;
      rf_vld_r    <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        pc_r     <= pc_nxt;
        tick_r   <= tick_nxt;
        halt_r   <= halt_nxt;
        skip_r   <= skip_nxt;
        mwait_r  <= mwait_nxt;
        ldpend_r <= ldpend_nxt;
        lddest_r <= lddest_nxt;
        if (wr_en) begin
          rf_vld_r[wr_idx] <= 1'b1;
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_started_r <= in_started;
      s1_instr_r   <= in_instr_word;
      s1_done_r    <= in_mem_done;
      s1_rdata_r   <= in_mem_rdata;
      src_byp_r    <= s1_adv && wr_en && (wr_idx == rd_src);
      tgt_byp_r    <= s1_adv && wr_en && (wr_idx == rd_tgt);
      src_vld_r    <= rf_vld_r[rd_src];
      tgt_vld_r    <= rf_vld_r[rd_tgt];
      byp_data_r   <= wr_val;
    end
    if (s1_adv) begin
      next_pc_r    <= pc_nxt;
      mem_req_r    <= req_c;
      mem_write_r  <= write_c;
      mem_addr_r   <= addr_c;
      mem_wdata_r  <= wdata_c;
      reg_we_r     <= wr_en;
      reg_idx_r    <= wr_idx;
      reg_value_r  <= wr_val;
      halted_r     <= halt_nxt;
      busy_r       <= busy_c;
      tick_total_r <= tick_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_next_pc    = next_pc_r;
  assign out_mem_req    = mem_req_r;
  assign out_mem_write  = mem_write_r;
  assign out_mem_addr   = mem_addr_r;
  assign out_mem_wdata  = mem_wdata_r;
  assign out_reg_we     = reg_we_r;
  assign out_reg_idx    = reg_idx_r;
  assign out_reg_value  = reg_value_r;
  assign out_halted     = halted_r;
  assign out_busy_wait  = busy_r;
  assign out_tick_total = tick_total_r;

endmodule

// ===== tb/tb.sv =====
module tb;
  import toy_cpu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES   = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 120;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_TICKS    = 333;

  typedef struct {
    logic [PC_WIDTH-1:0]   next_pc;
    logic                  mem_req;
    logic                  mem_write;
    logic [DATA_WIDTH-1:0] mem_addr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  reg_we;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [DATA_WIDTH-1:0] reg_value;
    logic                  halted;
    logic                  busy_wait;
    logic [TICK_W-1:0]     tick_total;
  } tick_result_t;

  class cpu_tick_scoreboard;
    data_t              regs [NUM_REGS];
    pc_t                pc;
    logic [TICK_W-1:0]  ticks;
    bit                 halt_flag;
    bit                 skip_next;
    bit                 wait_mem;
    bit                 load_open;
    reg_idx_t           load_reg;
    tick_result_t       expected_ticks [$];
    int                 failures;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc        = '0;
      ticks     = '0;
      halt_flag = 0;
      skip_next = 0;
      wait_mem  = 0;
      load_open = 0;
      load_reg  = '0;
      failures  = 0;
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    // Advance the core model by one accepted tick and queue its result.
    function void note_tick(logic st, logic [INSTR_W-1:0] word, logic done, data_t rdata);
      tick_result_t r;
      opcode_t      op;
      reg_idx_t     d, s, t;
      data_t        imm, sv, tv, wr_val;
      reg_idx_t     wr_idx;
      bit           wr_en;
      bit           take;
      pc_t          npc;
      r = '{default: '0};
      wr_en  = 0;
      wr_val = '0;
      wr_idx = '0;
      if (st && !halt_flag) begin
        ticks = ticks + 1;
        if (skip_next) begin
          skip_next   = 0;
          r.busy_wait = 1;
        end else if (wait_mem) begin
          r.busy_wait = 1;
          if (done) begin
            if (load_open) begin
              wr_en  = 1;
              wr_idx = load_reg;
              wr_val = rdata;
            end
            wait_mem  = 0;
            load_open = 0;
          end
        end else begin
          op  = opcode_t'(word[OP_LSB +: 3]);
          d   = word[DST_LSB +: REG_IDX_W];
          s   = word[SRC_LSB +: REG_IDX_W];
          t   = word[TGT_LSB +: REG_IDX_W];
          imm = word[IMM_W-1:0];
          sv  = regs[s];
          tv  = regs[t];
          npc = pc + 1'b1;
          wr_idx = d;
          case (op)
            OP_ADD: begin
              wr_en  = 1;
              wr_val = sv + tv;
            end
            OP_ADDI: begin
              wr_en  = 1;
              wr_val = sv + imm;
            end
            OP_MUL: begin
              wr_en     = 1;
              wr_val    = sv[3:0] * sv[7:4];
              skip_next = 1;
            end
            OP_INV: begin
              wr_en  = 1;
              wr_val = ~sv;
            end
            OP_BR: begin
              case (d)
                BR_EQ:   take = (sv == tv);
                BR_NE:   take = (sv != tv);
                BR_LT:   take = ($signed(sv) < $signed(tv));
                default: take = 0;
              endcase
              if (take) begin
                npc       = imm;
                skip_next = 1;
              end
            end
            OP_LW: begin
              r.mem_req = 1;
              r.mem_addr = tv;
              wait_mem  = 1;
              load_open = 1;
              load_reg  = d;
            end
            OP_SW: begin
              r.mem_req   = 1;
              r.mem_write = 1;
              r.mem_addr  = tv;
              r.mem_wdata = sv;
              wait_mem    = 1;
              load_open   = 0;
            end
            default: halt_flag = 1;
          endcase
          pc = npc;
        end
      end
      if (wr_en) begin
        regs[wr_idx] = wr_val;
        r.reg_we     = 1;
        r.reg_idx    = wr_idx;
        r.reg_value  = wr_val;
      end
      r.next_pc    = pc;
      r.halted     = halt_flag;
      r.tick_total = ticks;
      expected_ticks.push_back(r);
    endfunction

    function void cmp_field(string name, logic [TICK_W-1:0] exp, logic [TICK_W-1:0] act);
      if (act !== exp) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp, act);
        failures++;
      end
    endfunction

    function void check_tick(tick_result_t act);
      tick_result_t exp;
      if (expected_ticks.size() == 0) begin
        $error("result transaction with no tick outstanding");
        failures++;
        return;
      end
      exp = expected_ticks.pop_front();
      cmp_field("next_pc",    TICK_W'(exp.next_pc),    TICK_W'(act.next_pc));
      cmp_field("mem_req",    TICK_W'(exp.mem_req),    TICK_W'(act.mem_req));
      cmp_field("mem_write",  TICK_W'(exp.mem_write),  TICK_W'(act.mem_write));
      cmp_field("mem_addr",   TICK_W'(exp.mem_addr),   TICK_W'(act.mem_addr));
      cmp_field("mem_wdata",  TICK_W'(exp.mem_wdata),  TICK_W'(act.mem_wdata));
      cmp_field("reg_we",     TICK_W'(exp.reg_we),     TICK_W'(act.reg_we));
      cmp_field("reg_idx",    TICK_W'(exp.reg_idx),    TICK_W'(act.reg_idx));
      cmp_field("reg_value",  TICK_W'(exp.reg_value),  TICK_W'(act.reg_value));
      cmp_field("halted",     TICK_W'(exp.halted),     TICK_W'(act.halted));
      cmp_field("busy_wait",  TICK_W'(exp.busy_wait),  TICK_W'(act.busy_wait));
      cmp_field("tick_total", exp.tick_total, act.tick_total);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_started;
  logic [INSTR_W-1:0]    in_instr_word;
  logic                  in_mem_done;
  logic [DATA_WIDTH-1:0] in_mem_rdata;
  logic                  out_valid;
  logic                  out_ready;
  logic [PC_WIDTH-1:0]   out_next_pc;
  logic                  out_mem_req;
  logic                  out_mem_write;
  logic [DATA_WIDTH-1:0] out_mem_addr;
  logic [DATA_WIDTH-1:0] out_mem_wdata;
  logic                  out_reg_we;
  logic [REG_IDX_W-1:0]  out_reg_idx;
  logic [DATA_WIDTH-1:0] out_reg_value;
  logic                  out_halted;
  logic                  out_busy_wait;
  logic [TICK_W-1:0]     out_tick_total;

  cpu_tick_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int idle_cycles   = 0;

  toy_cpu_execute_step u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_started     (in_started),
    .in_instr_word  (in_instr_word),
    .in_mem_done    (in_mem_done),
    .in_mem_rdata   (in_mem_rdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_pc    (out_next_pc),
    .out_mem_req    (out_mem_req),
    .out_mem_write  (out_mem_write),
    .out_mem_addr   (out_mem_addr),
    .out_mem_wdata  (out_mem_wdata),
    .out_reg_we     (out_reg_we),
    .out_reg_idx    (out_reg_idx),
    .out_reg_value  (out_reg_value),
    .out_halted     (out_halted),
    .out_busy_wait  (out_busy_wait),
    .out_tick_total (out_tick_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Note accepted ticks and check results against the model.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_tick(in_started, in_instr_word, in_mem_done, in_mem_rdata);
    if (rst_n && out_valid && out_ready)
      sb.check_tick('{out_next_pc, out_mem_req, out_mem_write, out_mem_addr, out_mem_wdata,
                      out_reg_we, out_reg_idx, out_reg_value, out_halted, out_busy_wait,
                      out_tick_total});
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random back-pressure, plus a long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [INSTR_W-1:0] make_word(opcode_t op, reg_idx_t d, reg_idx_t s,
                                                   reg_idx_t t, data_t imm);
    return {op, d, s, t, imm};
  endfunction

  task automatic send_tick(logic st, logic [INSTR_W-1:0] word, logic done, data_t rdata);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_started    <= st;
    in_instr_word <= word;
    in_mem_done   <= done;
    in_mem_rdata  <= rdata;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_exec(logic [INSTR_W-1:0] word);
    send_tick(1'b1, word, 1'b0, data_t'($urandom));
  endtask

  // Random programs: no halt, so every tick keeps the core running.
  task automatic run_random(int count);
    logic [INSTR_W-1:0] word;
    for (int i = 0; i < count; i++) begin
      word = INSTR_W'($urandom);
      word[OP_LSB +: 3] = 3'($urandom_range(OP_SW, OP_ADD));
      send_tick($urandom_range(99) < 92, word, $urandom_range(99) < 35, data_t'($urandom));
    end
  endtask

  initial begin
    in_valid      <= 1'b0;
    in_started    <= 1'b0;
    in_instr_word <= '0;
    in_mem_done   <= 1'b0;
    in_mem_rdata  <= '0;
    rst_n         <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored tick, every opcode, branch kinds, memory corner cases.
    send_tick(1'b0, make_word(OP_ADDI, 3'd1, 3'd0, 3'd0, 8'hff), 1'b1, 8'h5a);
    send_exec(make_word(OP_ADDI, 3'd1, 3'd0, 3'd0, 8'hff));
    send_exec(make_word(OP_ADDI, 3'd2, 3'd0, 3'd0, 8'h80));
    send_exec(make_word(OP_ADD,  3'd3, 3'd1, 3'd2, 8'h00));
    send_exec(make_word(OP_ADD,  3'd7, 3'd1, 3'd1, 8'h00));
    send_exec(make_word(OP_MUL,  3'd4, 3'd1, 3'd7, 8'h3c));
    send_tick(1'b1, 20'hfffff, 1'b1, 8'hff);
    send_exec(make_word(OP_INV,  3'd5, 3'd2, 3'd0, 8'h00));
    // Taken branch to the top of the address space, then wrap the PC.
    send_exec(make_word(OP_BR,   BR_EQ, 3'd0, 3'd0, 8'hff));
    send_exec(make_word(OP_ADDI, 3'd6, 3'd0, 3'd0, 8'h01));
    send_exec(make_word(OP_ADDI, 3'd6, 3'd7, 3'd7, 8'h00));
    send_exec(make_word(OP_BR,   BR_NE, 3'd1, 3'd2, 8'h10));
    send_exec(make_word(OP_ADD,  3'd0, 3'd0, 3'd0, 8'h00));
    send_exec(make_word(OP_BR,   BR_LT, 3'd2, 3'd1, 8'h00));
    send_exec(make_word(OP_ADD,  3'd0, 3'd0, 3'd0, 8'h00));
    send_exec(make_word(OP_BR,   BR_LT, 3'd1, 3'd2, 8'h40));
    send_exec(make_word(OP_BR,   BR_EQ, 3'd1, 3'd2, 8'h40));
    send_exec(make_word(OP_BR,   BR_NE, 3'd1, 3'd1, 8'h40));
    send_exec(make_word(OP_BR,   3'd5,  3'd1, 3'd2, 8'h40));
    // Load: completion on the issuing tick is not seen, then a pause.
    send_tick(1'b1, make_word(OP_LW, 3'd6, 3'd0, 3'd1, 8'h00), 1'b1, 8'h11);
    send_tick(1'b1, make_word(OP_ADDI, 3'd6, 3'd0, 3'd0, 8'h22), 1'b0, 8'h33);
    send_tick(1'b0, '0, 1'b1, 8'h44);
    send_tick(1'b1, 20'h00000, 1'b1, 8'ha5);
    send_tick(1'b1, make_word(OP_ADDI, 3'd0, 3'd6, 3'd0, 8'h01), 1'b1, 8'h77);
    send_exec(make_word(OP_SW, 3'd0, 3'd1, 3'd2, 8'h00));
    send_tick(1'b1, 20'hfffff, 1'b1, 8'hc3);

    send_idle_pct = 18;
    recv_idle_pct = 48;
    run_random(100);
    hold_requests++;
    run_random(PHASE_TICKS - 100);
    send_idle_pct = 48;
    recv_idle_pct = 18;
    run_random(PHASE_TICKS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_TICKS);

    // Halt, then ticks that must all be ignored.
    send_exec(make_word(OP_HALT, 3'd0, 3'd0, 3'd0, 8'h00));
    send_tick(1'b1, make_word(OP_ADDI, 3'd1, 3'd0, 3'd0, 8'h01), 1'b1, 8'h99);
    send_tick(1'b1, make_word(OP_LW, 3'd2, 3'd0, 3'd1, 8'h00), 1'b0, 8'h00);
    send_tick(1'b0, '0, 1'b0, 8'h00);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
